/* design/rsbs_pkg.sv */
// Shared types and constants for the record sorter.
// Used by rsbs_cmp and the top level; depends on nothing else.
package rsbs_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int KEY_W       = 6;
    localparam int REC_W       = 59;

    typedef struct packed {
        logic [5:0]         src_id;
        logic [5:0]         dst_id;
        logic [14:0]        res_pos;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic               last_record;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         out_src_id;
        logic [5:0]         out_dst_id;
        logic [14:0]        out_res_pos;
        logic signed [15:0] out_value_a;
        logic signed [15:0] out_value_b;
        logic               out_last;
        logic               overflow;
    } t_out_item;

    typedef struct packed {
        logic [5:0]  src_id;
        logic [5:0]  dst_id;
        logic [14:0] res_pos;
        logic [15:0] value_a;
        logic [15:0] value_b;
    } t_rec;

    typedef struct packed {
        logic clear;
        logic update;
    } t_cmp_ctl;

    typedef struct packed {
        logic match;
        logic above;
    } t_cmp_res;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_CHECK
    } t_state;

endpackage

/* design/rsbs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module rsbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/rsbs_cmp.sv */
// Shared key comparator: tests a stored key against the key of the current pass
// and tracks the smallest key above it for the next pass. Depends on rsbs_pkg.
module rsbs_cmp (
    input  logic                        i_clk,
    input  rsbs_pkg::t_cmp_ctl          i_ctl,
    input  logic [rsbs_pkg::KEY_W-1:0]  i_key,
    input  logic [rsbs_pkg::KEY_W-1:0]  i_cur_key,
    output rsbs_pkg::t_cmp_res          o_res,
    output logic [rsbs_pkg::KEY_W-1:0]  o_next_key
);

    localparam logic [rsbs_pkg::KEY_W:0] NONE = '1;

    logic [rsbs_pkg::KEY_W:0] r_min;
    logic [rsbs_pkg::KEY_W:0] s_min;

    always_comb begin
        o_res.match = (i_key == i_cur_key);
        o_res.above = (i_key > i_cur_key);
        s_min       = r_min;
        if (i_ctl.update && o_res.above && ({1'b0, i_key} < r_min)) begin
            s_min = {1'b0, i_key};
        end
    end

    // The smallest key seen above the current one, including this record.
    assign o_next_key = s_min[rsbs_pkg::KEY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_min <= NONE;
        end else if (i_ctl.update) begin
            r_min <= s_min;
        end
    end

endmodule

/* design/record_sorter_by_source_id.sv */
// Top level of the record sorter: load sequencer, record store and output register.
// Depends on rsbs_pkg, rsbs_ram and rsbs_cmp.
//
//   Channel  Signals                      Direction  Moves
//   input    i_valid, o_ready, i_item     in         one record per item
//   output   o_valid, i_ready, o_item     out        one sorted record per item
//
// Loading accepts one item per cycle. After the item marked last, the sequencer makes
// one pass over the store for each distinct source id, with a RAM read and then a
// compare for every stored record; the first pass is for id 0, so a set with no id 0
// takes one extra pass. The single RAM read port and the shared comparator set the
// read-then-compare steps. While sorting and emitting, o_ready is low; a stalled
// output holds the scan at a matching record and lengthens the sort.
// Reset (synchronous, active low) empties the store and clears the overflow flag.
module record_sorter_by_source_id (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rsbs_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output rsbs_pkg::t_out_item o_item
);

    rsbs_pkg::t_state               r_state, n_state;
    logic [rsbs_pkg::CNT_W-1:0]     r_count;
    logic [rsbs_pkg::CNT_W-1:0]     r_emit;
    logic [rsbs_pkg::IDX_W-1:0]     r_idx;
    logic [rsbs_pkg::KEY_W-1:0]     r_key;
    logic                           r_ovf;
    logic                           r_out_valid;
    rsbs_pkg::t_out_item            r_out_item;

    logic                           s_in_fire;
    logic                           s_full;
    logic                           s_start;
    logic                           s_emit;
    logic                           s_step;
    logic                           s_last_rec;
    logic                           s_pass_end;
    logic                           s_done;
    logic                           s_out_free;
    logic [rsbs_pkg::CNT_W-1:0]     s_emit_next;
    rsbs_pkg::t_rec                 s_wr_rec;
    rsbs_pkg::t_rec                 s_rd_rec;
    rsbs_pkg::t_cmp_ctl             s_cmp_ctl;
    rsbs_pkg::t_cmp_res             s_cmp_res;
    logic [rsbs_pkg::KEY_W-1:0]     s_next_key;

    assign s_full      = (r_count == rsbs_pkg::CNT_W'(rsbs_pkg::MAX_RECORDS));
    assign s_in_fire   = i_valid && o_ready;
    assign s_out_free  = !r_out_valid || i_ready;
    assign s_last_rec  = ((rsbs_pkg::CNT_W'(r_idx) + rsbs_pkg::CNT_W'(1)) == r_count);
    assign s_emit_next = r_emit + rsbs_pkg::CNT_W'(1);

    assign s_wr_rec.src_id  = i_item.src_id;
    assign s_wr_rec.dst_id  = i_item.dst_id;
    assign s_wr_rec.res_pos = i_item.res_pos;
    assign s_wr_rec.value_a = i_item.value_a;
    assign s_wr_rec.value_b = i_item.value_b;

    rsbs_ram #(
        .WIDTH (rsbs_pkg::REC_W),
        .DEPTH (rsbs_pkg::MAX_RECORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (s_in_fire && !s_full),
        .i_wr_addr (r_count[rsbs_pkg::IDX_W-1:0]),
        .i_wr_data (s_wr_rec),
        .i_rd_addr (r_idx),
        .o_rd_data (s_rd_rec)
    );

    rsbs_cmp u_cmp (
        .i_clk      (i_clk),
        .i_ctl      (s_cmp_ctl),
        .i_key      (s_rd_rec.src_id),
        .i_cur_key  (r_key),
        .o_res      (s_cmp_res),
        .o_next_key (s_next_key)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsbs_pkg::ST_LOAD: begin
                if (s_in_fire && i_item.last_record) begin
                    n_state = rsbs_pkg::ST_READ;
                end
            end
            rsbs_pkg::ST_READ: begin
                n_state = rsbs_pkg::ST_CHECK;
            end
            rsbs_pkg::ST_CHECK: begin
                if (s_done) begin
                    n_state = rsbs_pkg::ST_LOAD;
                end else if (s_step) begin
                    n_state = rsbs_pkg::ST_READ;
                end
            end
            default: begin
                n_state = rsbs_pkg::ST_LOAD;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_ready          = 1'b0;
        s_start          = 1'b0;
        s_emit           = 1'b0;
        s_step           = 1'b0;
        s_pass_end       = 1'b0;
        s_done           = 1'b0;
        s_cmp_ctl.clear  = 1'b0;
        s_cmp_ctl.update = 1'b0;
        case (r_state)
            rsbs_pkg::ST_LOAD: begin
                o_ready         = 1'b1;
                s_start         = s_in_fire && i_item.last_record;
                s_cmp_ctl.clear = s_start;
            end
            rsbs_pkg::ST_READ: begin
                o_ready = 1'b0;
            end
            rsbs_pkg::ST_CHECK: begin
                s_emit           = s_cmp_res.match && s_out_free;
                s_step           = !s_cmp_res.match || s_out_free;
                s_cmp_ctl.update = s_step;
                s_pass_end       = s_step && s_last_rec;
                s_done           = s_pass_end &&
                                   ((s_emit ? s_emit_next : r_emit) == r_count);
                s_cmp_ctl.clear  = s_pass_end;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsbs_pkg::ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_emit      <= '0;
            r_idx       <= '0;
            r_key       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_in_fire) begin
                if (s_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + rsbs_pkg::CNT_W'(1);
                end
            end
            if (s_start) begin
                r_idx  <= '0;
                r_key  <= '0;
                r_emit <= '0;
            end
            if (s_emit) begin
                r_emit <= s_emit_next;
            end
            if (s_done) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (s_pass_end) begin
                r_idx <= '0;
                r_key <= s_next_key;
            end else if (s_step) begin
                r_idx <= r_idx + rsbs_pkg::IDX_W'(1);
            end
            if (s_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_out_item.out_src_id  <= s_rd_rec.src_id;
            r_out_item.out_dst_id  <= s_rd_rec.dst_id;
            r_out_item.out_res_pos <= s_rd_rec.res_pos;
            r_out_item.out_value_a <= s_rd_rec.value_a;
            r_out_item.out_value_b <= s_rd_rec.value_b;
            r_out_item.out_last    <= (s_emit_next == r_count);
            r_out_item.overflow    <= r_ovf;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rsbs_pkg::CNT_W'(rsbs_pkg::MAX_RECORDS))
        else $error("record count exceeds the store");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsbs_pkg::ST_CHECK || r_state == rsbs_pkg::ST_READ)
        |-> (rsbs_pkg::CNT_W'(r_idx) < r_count))
        else $error("scan index beyond loaded records");

    // The final pass may go on scanning after its last item has been emitted.
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsbs_pkg::ST_CHECK) |-> (r_emit <= r_count))
        else $error("more items emitted than records loaded");

    a_done_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_done |=> (r_count == '0 && !r_ovf))
        else $error("set end did not empty the store");

endmodule
